// ===== hdl/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg: shared types, codes and character classes for the C subset lexer
// Token kinds, operator codes, lexer modes and the keyword and operator
// lookup functions.
// ----------------------------------------------------------------------------
package csl_pkg;

   // Token kind codes as seen on the result channel
   typedef enum logic [3:0] {
      KIND_ID       = 4'd0,
      KIND_BASIC    = 4'd1,
      KIND_DO       = 4'd2,
      KIND_IF       = 4'd3,
      KIND_WHILE    = 4'd4,
      KIND_ELSE     = 4'd5,
      KIND_MAIN     = 4'd6,
      KIND_BREAK    = 4'd7,
      KIND_NUMBER   = 4'd8,
      KIND_REAL     = 4'd9,
      KIND_COMMENT  = 4'd10,
      KIND_OPERATOR = 4'd11,
      KIND_UNKNOWN  = 4'd12
   } token_kind_type;

   // Lexer mode: which kind of token is open
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_PAIR    = 3'd3,
      MODE_COMMENT = 3'd4
   } lex_mode_type;

   // Operator codes
   localparam logic [4:0] OP_LPAREN  = 5'd0;
   localparam logic [4:0] OP_RPAREN  = 5'd1;
   localparam logic [4:0] OP_LBRACK  = 5'd2;
   localparam logic [4:0] OP_RBRACK  = 5'd3;
   localparam logic [4:0] OP_LBRACE  = 5'd4;
   localparam logic [4:0] OP_RBRACE  = 5'd5;
   localparam logic [4:0] OP_PLUS    = 5'd6;
   localparam logic [4:0] OP_MINUS   = 5'd7;
   localparam logic [4:0] OP_STAR    = 5'd8;
   localparam logic [4:0] OP_SLASH   = 5'd9;
   localparam logic [4:0] OP_PERCENT = 5'd10;
   localparam logic [4:0] OP_LT      = 5'd11;
   localparam logic [4:0] OP_GT      = 5'd12;
   localparam logic [4:0] OP_ASSIGN  = 5'd13;
   localparam logic [4:0] OP_SEMI    = 5'd14;
   localparam logic [4:0] OP_COMMA   = 5'd15;
   localparam logic [4:0] OP_INC     = 5'd16;
   localparam logic [4:0] OP_DEC     = 5'd17;
   localparam logic [4:0] OP_LE      = 5'd18;
   localparam logic [4:0] OP_GE      = 5'd19;
   localparam logic [4:0] OP_NE      = 5'd20;
   localparam logic [4:0] OP_EQ      = 5'd21;
   localparam logic [4:0] OP_LAND    = 5'd22;
   localparam logic [4:0] OP_LOR     = 5'd23;
   localparam logic [4:0] OP_NOT     = 5'd24;
   localparam logic [4:0] OP_AMP     = 5'd25;
   localparam logic [4:0] OP_BAR     = 5'd26;
   localparam logic [4:0] OP_NONE    = 5'd0;

   // Characters with a special role
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Widest keyword window over the allowed keyword lengths
   localparam int KW_WIN_MAX_W = 64;
   localparam int KW_COUNT     = 10;

   // Keyword set, packed first byte highest
   localparam logic [KW_WIN_MAX_W-1:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0000_0069_6E74,   // int
      64'h0000_0066_6C6F_6174,   // float
      64'h0000_0000_6368_6172,   // char
      64'h0000_0000_766F_6964,   // void
      64'h0000_0000_0000_646F,   // do
      64'h0000_0000_0000_6966,   // if
      64'h0000_0077_6869_6C65,   // while
      64'h0000_0000_656C_7365,   // else
      64'h0000_0000_6D61_696E,   // main
      64'h0000_0062_7265_616B    // break
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd4, 4'd4, 4'd2, 4'd2, 4'd5, 4'd4, 4'd4, 4'd5
   };
   localparam token_kind_type KW_KIND [KW_COUNT] = '{
      KIND_BASIC, KIND_BASIC, KIND_BASIC, KIND_BASIC, KIND_DO,
      KIND_IF, KIND_WHILE, KIND_ELSE, KIND_MAIN, KIND_BREAK
   };

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } op_hit_type;

   typedef struct packed {
      logic       hit;
      logic       comment;
      logic [4:0] code;
   } pair_hit_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   // Characters that may open a two-character operator or a comment
   function automatic logic starts_pair(input logic [7:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h3C || c == 8'h3E || c == 8'h3D ||
             c == 8'h21 || c == 8'h26 || c == 8'h7C || c == CH_SLASH;
   endfunction

   // Look up a one-character operator
   function automatic op_hit_type single_code(input logic [7:0] c);
      op_hit_type r;
      r.hit = 1'b1;
      unique case (c)
         8'h28:   r.code = OP_LPAREN;
         8'h29:   r.code = OP_RPAREN;
         8'h5B:   r.code = OP_LBRACK;
         8'h5D:   r.code = OP_RBRACK;
         8'h7B:   r.code = OP_LBRACE;
         8'h7D:   r.code = OP_RBRACE;
         8'h2B:   r.code = OP_PLUS;
         8'h2D:   r.code = OP_MINUS;
         8'h2A:   r.code = OP_STAR;
         8'h2F:   r.code = OP_SLASH;
         8'h25:   r.code = OP_PERCENT;
         8'h3C:   r.code = OP_LT;
         8'h3E:   r.code = OP_GT;
         8'h3D:   r.code = OP_ASSIGN;
         8'h3B:   r.code = OP_SEMI;
         8'h2C:   r.code = OP_COMMA;
         8'h21:   r.code = OP_NOT;
         8'h26:   r.code = OP_AMP;
         8'h7C:   r.code = OP_BAR;
         default: begin
            r.hit  = 1'b0;
            r.code = OP_NONE;
         end
      endcase
      return r;
   endfunction

   // Look up a two-character operator or the comment opener
   function automatic pair_hit_type pair_code(input logic [7:0] a, input logic [7:0] b);
      pair_hit_type r;
      r.hit     = 1'b1;
      r.comment = 1'b0;
      r.code    = OP_NONE;
      priority if (a == 8'h2B && b == 8'h2B) r.code = OP_INC;
      else if (a == 8'h2D && b == 8'h2D) r.code = OP_DEC;
      else if (a == 8'h3C && b == 8'h3D) r.code = OP_LE;
      else if (a == 8'h3E && b == 8'h3D) r.code = OP_GE;
      else if (a == 8'h21 && b == 8'h3D) r.code = OP_NE;
      else if (a == 8'h3D && b == 8'h3D) r.code = OP_EQ;
      else if (a == 8'h26 && b == 8'h26) r.code = OP_LAND;
      else if (a == 8'h7C && b == 8'h7C) r.code = OP_LOR;
      else if (a == CH_SLASH && b == CH_SLASH) r.comment = 1'b1;
      else r.hit = 1'b0;
      return r;
   endfunction

   // Match an identifier of up to eight bytes against the keyword set
   function automatic token_kind_type kw_kind(input logic [KW_WIN_MAX_W-1:0] win,
                                              input logic [3:0] len);
      token_kind_type k;
      k = KIND_ID;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (KW_LEN[i] == len && KW_TEXT[i] == win) k = KW_KIND[i];
      end
      return k;
   endfunction

endpackage

// ===== hdl/c_subset_lexer.sv =====
// ----------------------------------------------------------------------------
// c_subset_lexer: streaming tokeniser for a small C subset
// Classifies one source byte per cycle unless stalled and emits token
// descriptors with kind, operator code, first byte, row, column and length.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_*): one source byte per word, req_end_of_text on
//   the last byte flushes any token still open. Response channel (rsp_*):
//   one token descriptor per word; rsp_last_of_run marks the last token
//   caused by a given byte. A byte may cause no token, one or two.
//   Tokens caused by a byte appear in the cycle after it is taken.
//   Throughput: one byte per cycle while each byte causes at most one token
//   and rsp_stall is low; a byte that causes two tokens stalls the request
//   side, since the two-entry output buffer drains one word per cycle.
//   Back-pressure: req_stall rises while the buffer cannot be emptied in the
//   current cycle, so a stalled response side holds at most two tokens.
//   Reset: synchronous; the lexer returns to idle with row and column 1 and
//   the output buffer empty.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
   parameter int POS_WIDTH     = 16,
   parameter int KEYWORD_CHARS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_in,
   input  logic                 req_end_of_text,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output csl_pkg::token_kind_type rsp_token_kind,
   output logic [4:0]           rsp_op_code,
   output logic [7:0]           rsp_first_byte,
   output logic [POS_WIDTH-1:0] rsp_token_row,
   output logic [POS_WIDTH-1:0] rsp_token_column,
   output logic [POS_WIDTH-1:0] rsp_token_length,
   output logic                 rsp_last_of_run
);
   import csl_pkg::*;

   localparam int WIN_W = 8 * KEYWORD_CHARS;

   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef struct packed {
      token_kind_type kind;
      logic [4:0]     op;
      logic [7:0]     first;
      pos_type        row;
      pos_type        col;
      pos_type        len;
      logic           last;
   } token_type;

   // Lexer state
   lex_mode_type     mode_ff, mode_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic             dot_ff, dot_in;
   logic [7:0]       pend_ff, pend_in;
   pos_type          olen_ff, olen_in;
   pos_type          orow_ff, orow_in;
   pos_type          ocol_ff, ocol_in;
   pos_type          line_ff, line_in;
   pos_type          col_ff, col_in;

   // Output buffer
   token_type        slot0_ff, slot0_in;
   token_type        slot1_ff, slot1_in;
   logic [1:0]       cnt_ff, cnt_in;

   // Tokens of the current byte
   token_type        tok_a, tok_b, tok_c, res0, res1;
   logic             has_a, has_b, has_c;
   logic [1:0]       res_n;
   logic             consumed;
   lex_mode_type     mode_v;
   logic [WIN_W-1:0] win_v;
   logic             dot_v;
   logic [7:0]       pend_v;
   pos_type          olen_v, orow_v, ocol_v;
   pair_hit_type     pair_v;
   op_hit_type       single_v;
   logic             take, pop;

   function automatic pos_type sat_inc(input pos_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Descriptor of the token open in the given mode
   function automatic token_type close_tok(input lex_mode_type m,
                                           input logic [WIN_W-1:0] w,
                                           input logic d, input logic [7:0] p,
                                           input pos_type len, input pos_type r,
                                           input pos_type c);
      token_type t;
      op_hit_type s;
      s       = single_code(p);
      t.op    = OP_NONE;
      t.first = p;
      t.row   = r;
      t.col   = c;
      t.len   = len;
      t.last  = 1'b0;
      t.kind  = KIND_ID;
      unique case (m)
         MODE_IDENT: begin
            if (len > pos_type'(KEYWORD_CHARS)) t.kind = KIND_ID;
            else t.kind = kw_kind(KW_WIN_MAX_W'(w), len[3:0]);
         end
         MODE_NUMBER: t.kind = d ? KIND_REAL : KIND_NUMBER;
         MODE_PAIR: begin
            t.kind = KIND_OPERATOR;
            t.op   = s.code;
            t.len  = pos_type'(1);
         end
         MODE_COMMENT: begin
            t.kind  = KIND_COMMENT;
            t.first = CH_SLASH;
         end
         default: t.kind = KIND_ID;
      endcase
      return t;
   endfunction

   // Lex one byte: close, extend or open a token or emit a one-byte token, then flush on end of text
   always_comb begin
      mode_v   = mode_ff;
      win_v    = win_ff;
      dot_v    = dot_ff;
      pend_v   = pend_ff;
      olen_v   = olen_ff;
      orow_v   = orow_ff;
      ocol_v   = ocol_ff;
      consumed = 1'b0;
      has_a    = 1'b0;
      has_b    = 1'b0;
      tok_a    = close_tok(mode_ff, win_ff, dot_ff, pend_ff, olen_ff, orow_ff, ocol_ff);
      pair_v   = pair_code(pend_ff, req_char_in);
      single_v = single_code(req_char_in);

      unique case (mode_ff)
         MODE_COMMENT: begin
            if (req_char_in == CH_LF) begin
               has_a  = 1'b1;
               mode_v = MODE_IDLE;
            end else begin
               olen_v   = sat_inc(olen_ff);
               consumed = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_alpha(req_char_in) || is_digit(req_char_in)) begin
               if (olen_ff < pos_type'(KEYWORD_CHARS))
                  win_v = {win_ff[WIN_W-9:0], req_char_in};
               olen_v   = sat_inc(olen_ff);
               consumed = 1'b1;
            end else begin
               has_a  = 1'b1;
               mode_v = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(req_char_in) || req_char_in == CH_DOT) begin
               if (req_char_in == CH_DOT) dot_v = 1'b1;
               olen_v   = sat_inc(olen_ff);
               consumed = 1'b1;
            end else begin
               has_a  = 1'b1;
               mode_v = MODE_IDLE;
            end
         end
         MODE_PAIR: begin
            priority if (pair_v.hit && pair_v.comment) begin
               mode_v   = MODE_COMMENT;
               olen_v   = pos_type'(2);
               consumed = 1'b1;
            end else if (pair_v.hit) begin
               has_a     = 1'b1;
               tok_a.op  = pair_v.code;
               tok_a.len = pos_type'(2);
               mode_v    = MODE_IDLE;
               consumed  = 1'b1;
            end else begin
               has_a  = 1'b1;
               mode_v = MODE_IDLE;
            end
         end
         default: ;
      endcase

      // Start a token or emit a one-byte token
      tok_b.kind  = KIND_UNKNOWN;
      tok_b.op    = OP_NONE;
      tok_b.first = req_char_in;
      tok_b.row   = line_ff;
      tok_b.col   = col_ff;
      tok_b.len   = pos_type'(1);
      tok_b.last  = 1'b0;
      if (!consumed && !is_space(req_char_in)) begin
         priority if (is_alpha(req_char_in) || is_digit(req_char_in) ||
                      req_char_in == CH_DOT || starts_pair(req_char_in)) begin
            if (is_alpha(req_char_in)) mode_v = MODE_IDENT;
            else if (starts_pair(req_char_in)) mode_v = MODE_PAIR;
            else mode_v = MODE_NUMBER;
            pend_v = req_char_in;
            orow_v = line_ff;
            ocol_v = col_ff;
            olen_v = pos_type'(1);
            win_v  = WIN_W'(req_char_in);
            dot_v  = (req_char_in == CH_DOT);
         end else if (single_v.hit) begin
            has_b      = 1'b1;
            tok_b.kind = KIND_OPERATOR;
            tok_b.op   = single_v.code;
         end else begin
            has_b = 1'b1;
         end
      end

      // Flush on end of text
      tok_c = close_tok(mode_v, win_v, dot_v, pend_v, olen_v, orow_v, ocol_v);
      has_c = req_end_of_text && (mode_v != MODE_IDLE);
      if (req_end_of_text) mode_v = MODE_IDLE;

      // Pack the tokens in order and mark the last one
      res0  = has_a ? tok_a : (has_b ? tok_b : tok_c);
      res1  = (has_a && has_b) ? tok_b : tok_c;
      res_n = 2'(has_a) + 2'(has_b) + 2'(has_c);
      if (res_n == 2'd1) res0.last = 1'b1;
      res1.last = 1'b1;
   end

   // Row and column counters
   always_comb begin
      if (req_char_in == CH_LF) begin
         line_in = sat_inc(line_ff);
         col_in  = pos_type'(1);
      end else begin
         line_in = line_ff;
         col_in  = sat_inc(col_ff);
      end
   end

   // Handshakes: take a byte only when the buffer is empty or drains this cycle
   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall));
   assign take      = req_valid && !req_stall;

   // Advance state on an accepted byte
   always_comb begin
      mode_in = mode_ff;
      win_in  = win_ff;
      dot_in  = dot_ff;
      pend_in = pend_ff;
      olen_in = olen_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (take) begin
         mode_in = mode_v;
         win_in  = win_v;
         dot_in  = dot_v;
         pend_in = pend_v;
         olen_in = olen_v;
         orow_in = orow_v;
         ocol_in = ocol_v;
      end
   end

   // Load the buffer with new tokens, else shift it down on a pop
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         slot0_in = res0;
         slot1_in = res1;
         cnt_in   = res_n;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         win_ff  <= '0;
         dot_ff  <= 1'b0;
         pend_ff <= '0;
         olen_ff <= '0;
         orow_ff <= pos_type'(1);
         ocol_ff <= pos_type'(1);
         line_ff <= pos_type'(1);
         col_ff  <= pos_type'(1);
         cnt_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         win_ff  <= win_in;
         dot_ff  <= dot_in;
         pend_ff <= pend_in;
         olen_ff <= olen_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         if (take) begin
            line_ff <= line_in;
            col_ff  <= col_in;
         end
         cnt_ff  <= cnt_in;
      end
   end

   // Hold the buffered descriptors
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Present the head of the buffer
   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_token_kind   = slot0_ff.kind;
   assign rsp_op_code      = slot0_ff.op;
   assign rsp_first_byte   = slot0_ff.first;
   assign rsp_token_row    = slot0_ff.row;
   assign rsp_token_column = slot0_ff.col;
   assign rsp_token_length = slot0_ff.len;
   assign rsp_last_of_run  = slot0_ff.last;

endmodule
